>>> hdl/tbt_pkg.sv
// shared types, widths, constants and the ln table for the thermistor converter
package tbt_pkg;

    // converter resolution and full-scale code
    localparam int ADC_BITS = 10;
    localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
    localparam int MSB_W = $clog2(ADC_BITS);

    // fixed-point widths
    localparam int R0_W    = 20;
    localparam int BETA_W  = 16;
    localparam int T0_W    = 16;
    localparam int CFG_W   = 20;
    localparam int LN_W    = 20;
    localparam int L_W     = LN_W + 1;
    localparam int KC_W    = 17;
    localparam int LK_W    = L_W + KC_W;
    localparam int B100_W  = 23;
    localparam int DEN_W   = 41;
    localparam int AN_W    = 55;
    localparam int T_DVS_W = 39;
    localparam int R_DVS_W = ADC_BITS;
    localparam int RDVD_W  = ADC_BITS + R0_W + 1;
    localparam int TEMP_W  = 16;
    localparam int RES_W   = 24;
    localparam int NUM_CELLS = AN_W;

    localparam int LN2_Q16 = 45426;
    localparam int ZERO_C_CENTI_K = 27315;
    localparam int BETA_SCALE = 100;

    // register indexes
    localparam logic [1:0] REG_R0   = 2'd0;
    localparam logic [1:0] REG_BETA = 2'd1;
    localparam logic [1:0] REG_T0   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef struct packed {
        logic zero;
        logic full;
        logic bad;
        logic neg;
    } flags_t;

    // one division cell carries both quotients side by side
    typedef struct packed {
        logic                 valid;
        flags_t               flags;
        logic [T_DVS_W-1:0]   t_rem;
        logic [AN_W-1:0]      t_dq;
        logic [T_DVS_W-1:0]   t_dvs;
        logic [R_DVS_W-1:0]   r_rem;
        logic [AN_W-1:0]      r_dq;
        logic [R_DVS_W-1:0]   r_dvs;
    } cell_t;

    // ln(1 + i/16) in q16
    function automatic logic [15:0] ln_entry(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3973;
            5'd2:    v = 16'd7719;
            5'd3:    v = 16'd11262;
            5'd4:    v = 16'd14624;
            5'd5:    v = 16'd17822;
            5'd6:    v = 16'd20870;
            5'd7:    v = 16'd23784;
            5'd8:    v = 16'd26573;
            5'd9:    v = 16'd29248;
            5'd10:   v = 16'd31818;
            5'd11:   v = 16'd34292;
            5'd12:   v = 16'd36675;
            5'd13:   v = 16'd38975;
            5'd14:   v = 16'd41197;
            5'd15:   v = 16'd43346;
            5'd16:   v = 16'd45426;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/tbt_ln.sv
// two-stage natural log in q16 by table lookup with linear interpolation
module tbt_ln
(
    input  logic                          clk,
    input  logic [tbt_pkg::ADC_BITS-1:0]  x,
    output logic [tbt_pkg::LN_W-1:0]      ln
);

    logic [tbt_pkg::MSB_W-1:0] msb;
    logic [tbt_pkg::ADC_BITS+15:0] shifted;
    logic [15:0] frac;
    logic [15:0] lo;
    logic [15:0] hi;

    logic [tbt_pkg::MSB_W-1:0] msb_reg;
    logic [15:0] lo_reg;
    logic [11:0] diff_reg;
    logic [11:0] rem_reg;

    logic [23:0] prod;
    logic [16:0] lm;
    logic [tbt_pkg::LN_W-1:0] ln_next;
    logic [tbt_pkg::LN_W-1:0] ln_reg;

    // normalize: leading one position and fraction bits below it
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < tbt_pkg::ADC_BITS; i++)
        begin
            if (x[i])
            begin
                msb = tbt_pkg::MSB_W'(i);
            end
        end
        shifted = {x, 16'b0} >> msb;
        frac = shifted[15:0];
        lo = tbt_pkg::ln_entry({1'b0, frac[15:12]});
        hi = tbt_pkg::ln_entry({1'b0, frac[15:12]} + 5'd1);
    end

    always_ff @(posedge clk)
    begin
        msb_reg  <= msb;
        lo_reg   <= lo;
        diff_reg <= 12'(hi - lo);
        rem_reg  <= frac[11:0];
    end

    // interpolate, round half up, add exponent times ln2
    always_comb
    begin
        prod = diff_reg * rem_reg;
        lm = 17'(lo_reg) + 17'((prod + 24'd2048) >> 12);
        ln_next = tbt_pkg::LN_W'(msb_reg) * tbt_pkg::LN_W'(tbt_pkg::LN2_Q16)
                  + tbt_pkg::LN_W'(lm);
    end

    always_ff @(posedge clk)
    begin
        ln_reg <= ln_next;
    end

    assign ln = ln_reg;

endmodule

>>> hdl/tbt_cell.sv
// one restoring division step for the temperature and resistance quotients
module tbt_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  tbt_pkg::cell_t  din,
    output tbt_pkg::cell_t  dout
);

    logic [tbt_pkg::T_DVS_W:0]   t_trial;
    logic [tbt_pkg::T_DVS_W+1:0] t_diff;
    logic [tbt_pkg::R_DVS_W:0]   r_trial;
    logic [tbt_pkg::R_DVS_W+1:0] r_diff;
    tbt_pkg::cell_t              cell_next;
    logic                        valid_reg;
    tbt_pkg::cell_t              cell_reg;

    always_comb
    begin
        t_trial = {din.t_rem, din.t_dq[tbt_pkg::AN_W-1]};
        t_diff  = {1'b0, t_trial} - {2'b0, din.t_dvs};
        r_trial = {din.r_rem, din.r_dq[tbt_pkg::AN_W-1]};
        r_diff  = {1'b0, r_trial} - {2'b0, din.r_dvs};

        cell_next = din;
        cell_next.t_rem = t_diff[tbt_pkg::T_DVS_W+1] ? t_trial[tbt_pkg::T_DVS_W-1:0]
                                                       : t_diff[tbt_pkg::T_DVS_W-1:0];
        cell_next.t_dq  = {din.t_dq[tbt_pkg::AN_W-2:0], ~t_diff[tbt_pkg::T_DVS_W+1]};
        cell_next.r_rem = r_diff[tbt_pkg::R_DVS_W+1] ? r_trial[tbt_pkg::R_DVS_W-1:0]
                                                       : r_diff[tbt_pkg::R_DVS_W-1:0];
        cell_next.r_dq  = {din.r_dq[tbt_pkg::AN_W-2:0], ~r_diff[tbt_pkg::R_DVS_W+1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    always_comb
    begin
        dout = cell_reg;
        dout.valid = valid_reg;
    end

endmodule

>>> hdl/thermistor_beta_temperature.sv
// ntc thermistor beta-equation converter: adc code to temperature and resistance
// throughput: one transaction per cycle, busy stays low; a result strobes on done
// after the start transaction has passed 7 front stages, a row of 55 division
// cells (one quotient bit per cell) and the output register
// reset: async active low, clears the valid pipe and loads the register defaults
// the receiver cannot stall: each result is on the ports for exactly one cycle
module thermistor_beta_temperature
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tbt_pkg::ADC_BITS-1:0]        adc_code,
    input  logic                                wr_en,
    input  logic [1:0]                          wr_index,
    input  logic [tbt_pkg::CFG_W-1:0]           wr_data,
    output logic                                done,
    output logic signed [tbt_pkg::TEMP_W-1:0]   temp_centi_c,
    output logic [tbt_pkg::RES_W-1:0]           resistance_ohms,
    output logic [1:0]                          status
);

    localparam int LATENCY = tbt_pkg::NUM_CELLS + 8;
    // largest quotient magnitudes that still land inside the 16-bit range
    localparam logic [tbt_pkg::AN_W-1:0] NEG_Q_MAX = tbt_pkg::AN_W'(32768 - 27315);
    localparam logic [tbt_pkg::AN_W-1:0] POS_Q_MAX = tbt_pkg::AN_W'(32767 + 27315);
    localparam logic signed [tbt_pkg::TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [tbt_pkg::TEMP_W-1:0] TEMP_MIN = -16'sh8000;
    localparam logic [tbt_pkg::RES_W-1:0] RES_MAX = '1;

    logic accept;

    // configuration registers
    logic [tbt_pkg::R0_W-1:0]          r0_reg;
    logic [tbt_pkg::BETA_W-1:0]        beta_reg;
    logic signed [tbt_pkg::T0_W-1:0]   t0_reg;

    // values that follow from configuration only
    logic signed [tbt_pkg::KC_W-1:0]   k_reg;
    logic [tbt_pkg::T0_W-1:0]          kabs_reg;
    logic                              kneg_reg;
    logic [tbt_pkg::B100_W-1:0]        b100_reg;
    logic [tbt_pkg::T_DVS_W-1:0]       an_hi_reg;
    logic signed [tbt_pkg::KC_W-1:0]   k_next;

    // front pipeline
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    tbt_pkg::flags_t f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg;
    logic [tbt_pkg::ADC_BITS-1:0] c1_reg;
    logic [tbt_pkg::ADC_BITS-1:0] rest1_reg, rest2_reg, rest3_reg, rest4_reg;
    logic [tbt_pkg::ADC_BITS-1:0] rest5_reg, rest6_reg;
    logic [tbt_pkg::RDVD_W-1:0]   rdvd2_reg, rdvd3_reg, rdvd4_reg, rdvd5_reg, rdvd6_reg;
    logic [tbt_pkg::LN_W-1:0]     lnc;
    logic [tbt_pkg::LN_W-1:0]     lnr;
    logic signed [tbt_pkg::L_W-1:0]   l4_reg;
    logic signed [tbt_pkg::LK_W-1:0]  lk5_reg;
    logic signed [tbt_pkg::DEN_W-1:0] den6_reg;
    logic signed [tbt_pkg::DEN_W-1:0] den_next;
    tbt_pkg::cell_t c7_next;
    tbt_pkg::cell_t c7_reg;
    logic           v7_reg;

    tbt_pkg::cell_t chain [0:tbt_pkg::NUM_CELLS];
    tbt_pkg::cell_t last;

    // output stage
    logic                              done_reg;
    logic signed [tbt_pkg::TEMP_W-1:0] temp_reg;
    logic [tbt_pkg::RES_W-1:0]         res_reg;
    logic [1:0]                        status_reg;
    logic signed [tbt_pkg::TEMP_W-1:0] temp_next;
    logic [tbt_pkg::RES_W-1:0]         res_next;
    logic [1:0]                        status_next;
    logic [tbt_pkg::RES_W-1:0]         res_sat;
    logic signed [17:0]                temp_wide;

    // fully pipelined: a new transaction every cycle
    assign busy = 1'b0;
    assign accept = start & ~busy;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_reg   <= tbt_pkg::R0_W'(10000);
            beta_reg <= tbt_pkg::BETA_W'(3950);
            t0_reg   <= tbt_pkg::T0_W'(2500);
        end
        else if (wr_en)
        begin
            case (wr_index)
                tbt_pkg::REG_R0:   r0_reg   <= wr_data[tbt_pkg::R0_W-1:0];
                tbt_pkg::REG_BETA: beta_reg <= wr_data[tbt_pkg::BETA_W-1:0];
                tbt_pkg::REG_T0:   t0_reg   <= wr_data[tbt_pkg::T0_W-1:0];
                default:           r0_reg   <= r0_reg;
            endcase
        end
    end

    // derived constants are registered from the configuration registers: k directly,
    // B*100*K through b100_reg and then an_hi_reg; transactions in flight are not held
    assign k_next = tbt_pkg::KC_W'(t0_reg) + tbt_pkg::KC_W'(tbt_pkg::ZERO_C_CENTI_K);

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        kneg_reg  <= k_next[tbt_pkg::KC_W-1];
        kabs_reg  <= k_next[tbt_pkg::KC_W-1] ? tbt_pkg::T0_W'(-k_next)
                                              : k_next[tbt_pkg::T0_W-1:0];
        b100_reg  <= tbt_pkg::B100_W'(beta_reg) * tbt_pkg::B100_W'(tbt_pkg::BETA_SCALE);
        // magnitude of B*100*K; the numerator is this times 2^16
        an_hi_reg <= tbt_pkg::T_DVS_W'(b100_reg) * tbt_pkg::T_DVS_W'(kabs_reg);
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // stage 1: capture code, complement leg, special codes
    always_ff @(posedge clk)
    begin
        c1_reg      <= adc_code;
        rest1_reg   <= tbt_pkg::FULL_SCALE - adc_code;
        f1_reg.zero <= (adc_code == '0);
        f1_reg.full <= (adc_code == tbt_pkg::FULL_SCALE);
        f1_reg.bad  <= 1'b0;
        f1_reg.neg  <= 1'b0;
    end

    // log of both divider legs; the registered results feed the log ratio
    tbt_ln u_ln_c
    (
        .clk (clk),
        .x   (c1_reg),
        .ln  (lnc)
    );

    tbt_ln u_ln_r
    (
        .clk (clk),
        .x   (rest1_reg),
        .ln  (lnr)
    );

    // stages 2..6
    always_ff @(posedge clk)
    begin
        // resistance dividend c*R0 + rest/2 for round to nearest
        rdvd2_reg <= tbt_pkg::RDVD_W'(c1_reg) * tbt_pkg::RDVD_W'(r0_reg)
                     + tbt_pkg::RDVD_W'(rest1_reg >> 1);
        rest2_reg <= rest1_reg;
        f2_reg    <= f1_reg;

        rdvd3_reg <= rdvd2_reg;
        rest3_reg <= rest2_reg;
        f3_reg    <= f2_reg;

        // log ratio of the legs
        l4_reg    <= $signed({1'b0, lnc}) - $signed({1'b0, lnr});
        rdvd4_reg <= rdvd3_reg;
        rest4_reg <= rest3_reg;
        f4_reg    <= f3_reg;

        lk5_reg   <= l4_reg * k_reg;
        rdvd5_reg <= rdvd4_reg;
        rest5_reg <= rest4_reg;
        f5_reg    <= f4_reg;

        den6_reg  <= den_next;
        rdvd6_reg <= rdvd5_reg;
        rest6_reg <= rest5_reg;
        f6_reg    <= f5_reg;
    end

    // denominator L*K + 6553600*B
    assign den_next = tbt_pkg::DEN_W'(lk5_reg)
                      + $signed({2'b0, b100_reg, 16'b0});

    // stage 7: load the division row
    always_comb
    begin
        c7_next.valid     = 1'b1;
        c7_next.flags     = f6_reg;
        c7_next.flags.bad = den6_reg[tbt_pkg::DEN_W-1] | (den6_reg == '0);
        c7_next.flags.neg = kneg_reg;
        c7_next.t_rem     = '0;
        c7_next.t_dq      = {an_hi_reg, 16'b0}
                            + tbt_pkg::AN_W'(den6_reg[tbt_pkg::T_DVS_W-1:1]);
        c7_next.t_dvs     = den6_reg[tbt_pkg::T_DVS_W-1:0];
        c7_next.r_rem     = '0;
        c7_next.r_dq      = tbt_pkg::AN_W'(rdvd6_reg);
        c7_next.r_dvs     = rest6_reg;
    end

    always_ff @(posedge clk)
    begin
        c7_reg <= c7_next;
    end

    always_comb
    begin
        chain[0] = c7_reg;
        chain[0].valid = v7_reg;
    end

    // row of division cells, one quotient bit each
    for (genvar g = 0; g < tbt_pkg::NUM_CELLS; g++)
    begin : g_cell
        tbt_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    assign last = chain[tbt_pkg::NUM_CELLS];

    // final: sign, offset to celsius, saturation and status
    always_comb
    begin
        res_sat = (last.r_dq > tbt_pkg::AN_W'(RES_MAX)) ? RES_MAX
                                                         : last.r_dq[tbt_pkg::RES_W-1:0];
        temp_wide = '0;
        temp_next = TEMP_MAX;
        res_next = res_sat;
        status_next = tbt_pkg::ST_OK;
        if (last.flags.zero)
        begin
            temp_next = TEMP_MAX;
            res_next = '0;
            status_next = tbt_pkg::ST_ZERO;
        end
        else if (last.flags.full)
        begin
            temp_next = TEMP_MIN;
            res_next = RES_MAX;
            status_next = tbt_pkg::ST_FULL;
        end
        else if (last.flags.bad)
        begin
            temp_next = TEMP_MAX;
            status_next = tbt_pkg::ST_SAT;
        end
        else if (last.flags.neg)
        begin
            if (last.t_dq > NEG_Q_MAX)
            begin
                temp_next = TEMP_MIN;
                status_next = tbt_pkg::ST_SAT;
            end
            else
            begin
                temp_wide = 18'sd0 - 18'sd27315 - $signed({1'b0, last.t_dq[16:0]});
                temp_next = temp_wide[tbt_pkg::TEMP_W-1:0];
            end
        end
        else
        begin
            if (last.t_dq > POS_Q_MAX)
            begin
                temp_next = TEMP_MAX;
                status_next = tbt_pkg::ST_SAT;
            end
            else
            begin
                temp_wide = $signed({1'b0, last.t_dq[16:0]}) - 18'sd27315;
                temp_next = temp_wide[tbt_pkg::TEMP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_reg   <= temp_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    assign done            = done_reg;
    assign temp_centi_c    = temp_reg;
    assign resistance_ohms = res_reg;
    assign status          = status_reg;

    // every accepted transaction comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after start");

    // nothing comes out that was not started
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a start");

    // code zero reads infinitely hot with zero resistance
    a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == tbt_pkg::ST_ZERO) |->
            (temp_centi_c == TEMP_MAX && resistance_ohms == '0))
        else $error("code zero result wrong");

    // full-scale code reads infinitely cold with saturated resistance
    a_full_code: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == tbt_pkg::ST_FULL) |->
            (temp_centi_c == TEMP_MIN && resistance_ohms == RES_MAX))
        else $error("full-scale result wrong");

endmodule

>>> tb/sv/thermistor_beta_temperature_test.sv
// testbench for the thermistor beta-equation converter with a self-checking scoreboard
`timescale 1ns / 1ps

module thermistor_beta_temperature_test;

    // register width mask, matching the hardware register size
    localparam logic [19:0] R0_MASK   = 20'hFFFFF;
    localparam int          DRAIN_CYC = 70;   // a little over the converter latency
    // index with no register behind it
    localparam logic [1:0]  REG_NONE  = 2'd3;

    // expected fields of one result transaction
    typedef struct {
        logic [15:0] temp;
        logic [23:0] res;
        logic [1:0]  st;
        logic [9:0]  code;
    } conv_result_t;

    // tracks the converter settings and predicts each transaction's result
    class conv_scoreboard;
        logic [19:0]  r0;
        logic [15:0]  beta;
        logic [15:0]  t0;
        conv_result_t pending_q[$];
        int           errors;
        longint       lnq[17];

        function new();
            r0 = 20'd10000;
            beta = 16'd3950;
            t0 = 16'd2500;
            errors = 0;
            lnq = '{0, 3973, 7719, 11262, 14624, 17822, 20870, 23784, 26573,
                    29248, 31818, 34292, 36675, 38975, 41197, 43346, 45426};
        endfunction

        function void set_reg(logic [1:0] idx, logic [19:0] data);
            if (idx == tbt_pkg::REG_R0)
                r0 = data & R0_MASK;
            else if (idx == tbt_pkg::REG_BETA)
                beta = data[15:0];
            else if (idx == tbt_pkg::REG_T0)
                t0 = data[15:0];
        endfunction

        // natural log in q16: octave times ln2 plus interpolated mantissa term
        function longint ln_fixed(longint unsigned x);
            longint unsigned oct, m, f, idx, rem, lo, hi, lm;
            oct = 0;
            while (oct < 16 && (x >> (oct + 1)) != 0)
                oct++;
            m = (x << 16) >> oct;
            f = (m - 65536) & 64'hFFFF;
            idx = f >> 12;
            rem = f & 64'hFFF;
            lo = lnq[idx];
            hi = lnq[idx + 1];
            lm = lo + (((hi - lo) * rem + 2048) >> 12);
            return longint'(oct) * tbt_pkg::LN2_Q16 + longint'(lm);
        endfunction

        // note an accepted input transaction and queue its expected result
        function void note_code(logic [9:0] code);
            conv_result_t e;
            longint unsigned c, rest, rr, an, q;
            longint lgap, kc, bs, den, num, tck, tv;
            e.code = code;
            c = code;
            if (c == 0)
            begin
                e.temp = 16'h7FFF;
                e.res = 24'd0;
                e.st = tbt_pkg::ST_ZERO;
            end
            else if (code == tbt_pkg::FULL_SCALE)
            begin
                e.temp = 16'h8000;
                e.res = 24'hFFFFFF;
                e.st = tbt_pkg::ST_FULL;
            end
            else
            begin
                rest = 1023 - c;
                rr = (c * r0 + rest / 2) / rest;
                e.res = (rr > 24'hFFFFFF) ? 24'hFFFFFF : rr[23:0];
                e.st = tbt_pkg::ST_OK;
                lgap = ln_fixed(c) - ln_fixed(rest);
                kc = longint'($signed(t0)) + tbt_pkg::ZERO_C_CENTI_K;
                bs = 64'sd6553600 * longint'(beta);
                den = lgap * kc + bs;
                if (den <= 0)
                begin
                    // pole of the equation or zero beta: hot saturation
                    e.temp = 16'h7FFF;
                    e.st = tbt_pkg::ST_SAT;
                end
                else
                begin
                    num = bs * kc;
                    an = (num < 0) ? longint'(-num) : num;
                    q = (an + longint'(den) / 2) / longint'(den);
                    tck = (num < 0) ? -longint'(q) : longint'(q);
                    tv = tck - tbt_pkg::ZERO_C_CENTI_K;
                    if (tv > 32767)
                    begin
                        tv = 32767;
                        e.st = tbt_pkg::ST_SAT;
                    end
                    else if (tv < -32768)
                    begin
                        tv = -32768;
                        e.st = tbt_pkg::ST_SAT;
                    end
                    e.temp = tv[15:0];
                end
            end
            pending_q.push_back(e);
        endfunction

        // compare one result transaction against the oldest expectation
        function void check_result(logic [15:0] temp, logic [23:0] res, logic [1:0] st);
            conv_result_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result temp=%0d res=%0d status=%0d",
                         $time, $signed(temp), res, st);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (temp !== e.temp)
            begin
                $display("%0t: code %0d temp expected %0d actual %0d",
                         $time, e.code, $signed(e.temp), $signed(temp));
                errors++;
            end
            if (res !== e.res)
            begin
                $display("%0t: code %0d resistance expected %0d actual %0d",
                         $time, e.code, e.res, res);
                errors++;
            end
            if (st !== e.st)
            begin
                $display("%0t: code %0d status expected %0d actual %0d",
                         $time, e.code, e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [tbt_pkg::ADC_BITS-1:0]       adc_code;
    logic                               wr_en;
    logic [1:0]                         wr_index;
    logic [tbt_pkg::CFG_W-1:0]          wr_data;
    logic                               done;
    logic signed [tbt_pkg::TEMP_W-1:0]  temp_centi_c;
    logic [tbt_pkg::RES_W-1:0]          resistance_ohms;
    logic [1:0]                         status;

    conv_scoreboard sb;
    int             idle_mode;   // 0: back to back, otherwise random gaps

    thermistor_beta_temperature u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .adc_code        (adc_code),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .done            (done),
        .temp_centi_c    (temp_centi_c),
        .resistance_ohms (resistance_ohms),
        .status          (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // monitor: input and result transactions are both taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_code(adc_code);
            if (done)
                sb.check_result(temp_centi_c, resistance_ohms, status);
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0 || r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 90);
    endfunction

    // drive one start transaction; busy is stable from the falling edge on
    task automatic send_code(logic [9:0] code);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        start <= 1'b1;
        adc_code <= code;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            adc_code <= 10'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // let the pipe empty before touching the registers
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] data);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
        wr_en <= 1'b0;
        wr_data <= 20'($urandom);
    endtask

    // codes weighted toward both ends of the scale, where the log is steep
    function automatic logic [9:0] rand_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 10'($urandom_range(0, 6));
        else if (r < 16)
            return 10'($urandom_range(1017, 1023));
        else
            return 10'($urandom);
    endfunction

    task automatic run_random(int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            if (i % 60 == 0)
                idle_mode = $urandom_range(0, 3);
            send_code(rand_code());
        end
    endtask

    initial
    begin
        int          ph;
        logic [19:0] r0_set[12];
        logic [19:0] b_set[12];
        logic [19:0] t_set[12];
        logic [9:0]  directed[$];
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        adc_code = '0;
        wr_en = 1'b0;
        wr_index = tbt_pkg::REG_R0;
        wr_data = '0;
        idle_mode = 1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: ends of the scale, midpoint, powers of two, bit patterns
        directed = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd511, 10'd512, 10'd1020, 10'd1021,
                     10'd1022, 10'd1023, 10'd4, 10'd16, 10'd64, 10'd256, 10'd768,
                     10'h2AA, 10'h155, 10'd0, 10'd1023, 10'd100};
        foreach (directed[i])
            send_code(directed[i]);
        run_random(150);

        // extremes of every register, then random settings (index 3 is a no-op)
        r0_set = '{20'd1, 20'd1000000, 20'hFFFFF, 20'd0, 20'd10000, 20'd47000, 20'd100,
                   20'd0, 20'd0, 20'd0, 20'd0, 20'd0};
        b_set  = '{20'd1, 20'd65535, 20'd0, 20'd3950, 20'hF0F6E, 20'd3380, 20'd65535,
                   20'd0, 20'd0, 20'd0, 20'd0, 20'd0};
        t_set  = '{20'hEC78, 20'd20000, 20'h8000, 20'h7FFF, 20'h0, 20'h95526, 20'hEC78,
                   20'd0, 20'd0, 20'd0, 20'd0, 20'd0};
        for (ph = 7; ph < 12; ph++)
        begin
            r0_set[ph] = 20'($urandom);
            b_set[ph] = 20'($urandom);
            t_set[ph] = 20'($urandom);
        end
        for (ph = 0; ph < 12; ph++)
        begin
            wait_drained();
            write_reg(tbt_pkg::REG_R0, r0_set[ph]);
            write_reg(tbt_pkg::REG_BETA, b_set[ph]);
            write_reg(tbt_pkg::REG_T0, t_set[ph]);
            if (ph % 3 == 0)
                write_reg(REG_NONE, 20'($urandom));
            send_code(10'd0);
            send_code(10'd1023);
            run_random(140);
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hdl/tbt_pkg.sv
hdl/tbt_ln.sv
hdl/tbt_cell.sv
hdl/thermistor_beta_temperature.sv
tb/sv/thermistor_beta_temperature_test.sv
